// ===== design/b64se_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

    // Character codes
    localparam logic [7:0] LINE_FEED = 8'd10;
    localparam logic [7:0] PAD_CHAR  = 8'd61;

    // Groups per line after reset (72 characters)
    localparam logic [7:0] GPL_RESET = 8'd18;

    // Deepest burst caused by one byte: four characters and two line feeds
    localparam int MAX_CHARS = 6;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    // One character waiting to leave the block
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } b64_char_t;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] b64_sym(input logic [5:0] six);
        logic [7:0] s;
        begin
            s = {2'b00, six};
            if (six < 6'd26)
                b64_sym = 8'd65 + s;
            else if (six < 6'd52)
                b64_sym = 8'd71 + s;
            else if (six < 6'd62)
                b64_sym = s - 8'd4;
            else if (six == 6'd62)
                b64_sym = 8'd43;
            else
                b64_sym = 8'd47;
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/base64_stream_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The first character of a group is valid in the cycle after the byte completing it is taken.
// Throughput: one character per cycle while out_ready is high, from a six-entry result register;
// a completing byte is taken when that register drains.
// Bytes that only fill the group are taken in any cycle, even while characters are draining.
// Reset: asynchronous, active low; empties the result register, clears the group state
// and loads 18 groups per line.
// ----------------------------------------------------------------------------
// base64_stream_encoder_unit
// Base64 stream encoder with line wrapping and '=' padding of a short final group.
// ----------------------------------------------------------------------------
module base64_stream_encoder_unit
    import b64se_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte input
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    // character output
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      char_out,
    output logic            last_char,
    // configuration
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    // State
    logic [7:0]       gpl_reg;
    logic [15:0]      pend_reg, pend_next;
    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       lgc_reg, lgc_next;
    b64_char_t        chars_reg [MAX_CHARS];
    b64_char_t        chars_next [MAX_CHARS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Datapath signals
    logic [23:0] grp_val;
    logic [1:0]  grp_len;
    logic        emit;
    logic        wrap;
    logic [7:0]  lgc_inc;
    logic        accept;
    logic        load;
    logic        pop;
    logic        buf_free;
    b64_char_t   burst [MAX_CHARS];
    logic [CNT_W-1:0] burst_cnt;

    // Output side
    assign out_valid = (cnt_reg != '0);
    assign char_out  = chars_reg[0].code;
    assign last_char = chars_reg[0].last;
    assign pop       = out_valid && out_ready;
    assign cfg_ready = 1'b1;

    // Group assembly; phase three behaves as phase zero
    always_comb
    begin
        case (phase_reg)
            2'd1:
            begin
                grp_val = {pend_reg[15:8], data_byte, 8'h00};
                grp_len = 2'd2;
            end
            2'd2:
            begin
                grp_val = {pend_reg, data_byte};
                grp_len = 2'd3;
            end
            default:
            begin
                grp_val = {data_byte, 16'h0000};
                grp_len = 2'd1;
            end
        endcase
    end

    assign emit    = (grp_len == 2'd3) || final_byte;
    assign lgc_inc = lgc_reg + 8'd1;
    assign wrap    = (lgc_inc == gpl_reg);

    // Take a byte when the burst register drains, or any byte that emits nothing
    assign buf_free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign in_ready = buf_free || !emit;
    assign accept   = in_valid && in_ready;
    assign load     = accept && emit;

    // Burst of characters caused by this byte
    always_comb
    begin
        burst[0] = '{code: b64_sym(grp_val[23:18]), last: 1'b0};
        burst[1] = '{code: b64_sym(grp_val[17:12]), last: 1'b0};
        burst[2] = '{code: (grp_len >= 2'd2) ? b64_sym(grp_val[11:6]) : PAD_CHAR,
                     last: 1'b0};
        burst[3] = '{code: (grp_len == 2'd3) ? b64_sym(grp_val[5:0]) : PAD_CHAR,
                     last: 1'b0};
        // wrap feed first, closing feed after it
        burst[4] = '{code: LINE_FEED, last: !wrap};
        burst[5] = '{code: LINE_FEED, last: 1'b1};
        burst_cnt = CNT_W'(4) + CNT_W'(wrap) + CNT_W'(final_byte);
    end

    // Next group state
    always_comb
    begin
        pend_next  = pend_reg;
        phase_next = phase_reg;
        lgc_next   = lgc_reg;
        if (accept)
        begin
            if (emit)
            begin
                pend_next  = 16'h0000;
                phase_next = 2'd0;
                lgc_next   = wrap ? 8'd0 : lgc_inc;
            end
            else if (grp_len == 2'd1)
            begin
                pend_next  = {data_byte, 8'h00};
                phase_next = 2'd1;
            end
            else
            begin
                pend_next  = {pend_reg[15:8], data_byte};
                phase_next = 2'd2;
            end
            if (final_byte)
                lgc_next = 8'd0;
        end
    end

    // Burst register: load whole, shift one out per transaction
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_CHARS; i++)
            chars_next[i] = chars_reg[i];
        if (load)
        begin
            cnt_next = burst_cnt;
            for (int i = 0; i < MAX_CHARS; i++)
                chars_next[i] = burst[i];
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_CHARS - 1; i++)
                chars_next[i] = chars_reg[i + 1];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpl_reg   <= GPL_RESET;
            pend_reg  <= 16'h0000;
            phase_reg <= 2'd0;
            lgc_reg   <= 8'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gpl_reg <= cfg_data;
            pend_reg  <= pend_next;
            phase_reg <= phase_next;
            lgc_reg   <= lgc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Character payload, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_CHARS; i++)
            chars_reg[i] <= chars_next[i];
    end

endmodule
`default_nettype wire

// ===== bench/b64_char_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_char_checker
// Passive checker for the base64 stream encoder. It follows the byte and
// configuration transactions, works out the character stream that each byte
// must cause, and compares every character transaction with the oldest
// character still owed.
// ----------------------------------------------------------------------------
module b64_char_checker
    import b64se_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte channel
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    // character channel
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] char_out,
    input  logic       last_char,
    // configuration channel
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // status towards the bench top
    output int         chars_owed,
    output int         fail_count
);

    // Alphabet, first character in the top byte
    localparam logic [511:0] ALPHA_STR =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic [7:0]  line_limit;      // groups per line
    logic [15:0] held_bytes;      // first byte in 15..8, second in 7..0
    logic [1:0]  held_count;      // bytes waiting for their group
    logic [7:0]  groups_on_line;  // wraps at 256
    b64_char_t   owed_q[$];

    function automatic logic [7:0] sextet_char(input logic [5:0] six);
        sextet_char = ALPHA_STR[511 - 8 * int'(six) -: 8];
    endfunction

    // Expected characters for one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [23:0] grp;
        int          nb;
        begin
            // a held count of three never occurs; it falls to the empty case
            case (held_count)
                2'd1:
                begin
                    grp = {held_bytes[15:8], b, 8'h00};
                    nb  = 2;
                end
                2'd2:
                begin
                    grp = {held_bytes, b};
                    nb  = 3;
                end
                default:
                begin
                    grp = {b, 16'h0000};
                    nb  = 1;
                end
            endcase

            if (nb == 3 || fin)
            begin
                owed_q.push_back({sextet_char(grp[23:18]), 1'b0});
                owed_q.push_back({sextet_char(grp[17:12]), 1'b0});
                owed_q.push_back({(nb >= 2) ? sextet_char(grp[11:6]) : PAD_CHAR, 1'b0});
                owed_q.push_back({(nb == 3) ? sextet_char(grp[5:0]) : PAD_CHAR, 1'b0});
                // a new register value takes effect at the next group
                groups_on_line = groups_on_line + 8'd1;
                if (groups_on_line == line_limit)
                begin
                    owed_q.push_back({LINE_FEED, 1'b0});
                    groups_on_line = 8'd0;
                end
                held_bytes = 16'h0000;
                held_count = 2'd0;
            end
            else if (nb == 1)
            begin
                held_bytes = {b, 8'h00};
                held_count = 2'd1;
            end
            else
            begin
                held_bytes[7:0] = b;
                held_count      = 2'd2;
            end

            // closing line feed, then back to the empty state
            if (fin)
            begin
                owed_q.push_back({LINE_FEED, 1'b1});
                held_bytes     = 16'h0000;
                held_count     = 2'd0;
                groups_on_line = 8'd0;
            end
        end
    endtask

    // Track transactions and compare characters
    always @(posedge clk or negedge rst_n)
    begin : track
        b64_char_t want;
        if (!rst_n)
        begin
            line_limit     = GPL_RESET;
            held_bytes     = 16'h0000;
            held_count     = 2'd0;
            groups_on_line = 8'd0;
            owed_q.delete();
            chars_owed     = 0;
            fail_count     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                line_limit = cfg_data;
            if (in_valid && in_ready)
                encode_byte(data_byte, final_byte);
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("char_out: expected none, actual %0d", char_out);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (char_out !== want.code)
                    begin
                        $error("char_out: expected %0d, actual %0d", want.code, char_out);
                        fail_count = fail_count + 1;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char: expected %0d, actual %0d", want.last, last_char);
                        fail_count = fail_count + 1;
                    end
                end
            end
            chars_owed = owed_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the base64 stream encoder. A short directed run
// covers padding, wrap on the final group and the alphabet ends; random
// payloads then run under several line lengths and back-pressure patterns,
// with the register rewritten between runs, often mid-payload.
// ----------------------------------------------------------------------------
module tb_top;
    import b64se_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] char_out;
    logic       last_char;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int chars_owed;
    int fail_count;
    int in_idle_pct;
    int out_idle_pct;
    int open_left;     // bytes still to send in the current payload
    int quiet_cycles;

    // {final, byte}; run with two groups per line
    logic [8:0] directed_seq [23] = '{
        9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h14D,  // wrap, one-byte tail
        9'h04D, 9'h161,                                          // two-byte tail
        9'h04D, 9'h061, 9'h16E,                                  // full group on final
        9'h001, 9'h002, 9'h003, 9'h004, 9'h005, 9'h106,          // line ends on final
        9'h180,                                                  // lone final byte
        9'h0FB, 9'h0EF, 9'h0BE,                                  // four '+' (sextet 62)
        9'h0AA                                                   // left pending
    };

    base64_stream_encoder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .last_char  (last_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    b64_char_checker char_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .last_char  (last_char),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .chars_owed (chars_owed),
        .fail_count (fail_count)
    );

    // 50 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Character receiver with random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One byte transaction; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic fin);
        begin
            while ($urandom_range(99) < in_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            data_byte  <= b;
            final_byte <= fin;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Register write transaction
    task automatic write_gpl(input logic [7:0] v);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Wait for every owed character, then let the block settle
    task automatic drain(input int settle);
        begin
            in_valid <= 1'b0;
            while (chars_owed != 0)
                @(negedge clk);
            repeat (settle) @(negedge clk);
        end
    endtask

    // Random payloads; the last one may stay open across a register write
    task automatic run_random(input int n_items);
        int         len_sel;
        int         pick;
        logic [7:0] b;
        begin
            repeat (n_items)
            begin
                if (open_left == 0)
                begin
                    len_sel = $urandom_range(9);
                    if (len_sel < 2)
                        open_left = $urandom_range(3, 1);
                    else if (len_sel < 8)
                        open_left = $urandom_range(60, 4);
                    else
                        open_left = $urandom_range(120, 61);
                end
                pick = $urandom_range(15);
                if (pick == 0)
                    b = 8'h00;
                else if (pick == 1)
                    b = 8'hFF;
                else
                    b = 8'($urandom);
                send_byte(b, open_left == 1);
                open_left = open_left - 1;
            end
        end
    endtask

    // Main sequence
    initial
    begin : stimulus
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'h00;
        final_byte   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 8'h00;
        in_idle_pct  = 14;
        out_idle_pct = 88;
        open_left    = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: two groups per line
        write_gpl(8'd2);
        for (i = 0; i < 23; i++)
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);

        // longest line, written with a byte still pending
        drain(SETTLE_CYCLES);
        write_gpl(8'd255);
        run_random(70);

        drain(SETTLE_CYCLES);
        write_gpl(8'd1);
        run_random(70);

        // slow sender, rarely stalling receiver
        in_idle_pct  = 88;
        out_idle_pct = 14;
        drain(SETTLE_CYCLES);
        write_gpl(8'd200);
        run_random(70);

        // usually lowered below the running group count
        drain(SETTLE_CYCLES);
        write_gpl(8'd2);
        run_random(70);

        // no stalls; zero leaves the count to wrap at 256 groups
        in_idle_pct  = 0;
        out_idle_pct = 0;
        drain(SETTLE_CYCLES);
        write_gpl(8'd0);
        run_random(100);

        drain(SETTLE_CYCLES);
        write_gpl(GPL_RESET);
        run_random(60);
        run_random(open_left);

        drain(TAIL_CYCLES);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
